// ----- sv/afr_pkg.sv -----
// Shared constants, fixed-point helpers and the CORDIC angle table for the field rotation block.
`default_nettype none

package afr_pkg;

  // Angle and pipeline defaults.
  localparam int DEF_ANGLE_BITS    = 32;
  localparam int DEF_CORDIC_STAGES = 30;

  // Vectors and sines are Q4.30 in 34 bits; the two bits above Q2.30 leave headroom for CORDIC growth.
  localparam int Q_FRAC = 30;
  localparam int VEC_W  = 34;
  localparam int PS_W   = Q_FRAC + 2;
  localparam int SQ_W   = 2 * Q_FRAC + 1;
  localparam int SQRT_STAGES = Q_FRAC + 1;

  localparam logic signed [VEC_W-1:0] K_GAIN  = VEC_W'(652032874);
  localparam logic signed [VEC_W-1:0] ONE_Q30 = VEC_W'(longint'(1) << Q_FRAC);

  typedef logic signed [VEC_W-1:0] vec_t;

  // Q4.30 product, rounded half up with a floor shift.
  function automatic vec_t mulq(input vec_t a, input vec_t b);
    logic signed [2*VEC_W-1:0] p;
    p = a * b;
    p = p + (2*VEC_W)'(longint'(1) << (Q_FRAC - 1));
    return VEC_W'(p >>> Q_FRAC);
  endfunction

  // Restoring division, used only while building constants.
  function automatic longint unsigned udiv(input longint unsigned a,
                                           input longint unsigned b);
    longint unsigned r;
    longint unsigned q;
    r = 0;
    q = 0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[62:0], a[j]};
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q60 by its power series.
  function automatic longint atan_inv(input longint n);
    longint p;
    longint sum;
    longint term;
    int     k;
    p = longint'(udiv(longint'(1) << 60, n));
    sum = 0;
    k = 0;
    while (p != 0) begin
      term = longint'(udiv(p, longint'(2 * k + 1)));
      if (k[0]) sum = sum - term;
      else      sum = sum + term;
      p = longint'(udiv(p, n * n));
      k++;
    end
    return sum;
  endfunction

  // Angle of CORDIC stage i as a binary angle of abits bits, rounded.
  function automatic longint cordic_angle(input int i, input int abits);
    longint twopi;
    longint at;
    longint term;
    longint unsigned r;
    longint unsigned q;
    int k;
    twopi = 8 * (4 * atan_inv(5) - atan_inv(239));
    at = 0;
    if (i == 0) begin
      at = twopi / 8;
    end else begin
      k = 0;
      while (60 - i * (2 * k + 1) >= 0) begin
        term = longint'(udiv(longint'(1) << (60 - i * (2 * k + 1)), longint'(2 * k + 1)));
        if (k[0]) at = at - term;
        else      at = at + term;
        k++;
      end
    end
    r = at;
    q = 0;
    for (int b = 0; b <= abits; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= longint'(twopi)) begin
        r = r - twopi;
        q[0] = 1'b1;
      end
    end
    return longint'((q + 1) >> 1);
  endfunction

endpackage

`default_nettype wire

// ----- sv/afr_sincos.sv -----
// Rotation-mode CORDIC chain giving sine and cosine of a binary angle.
`default_nettype none

module afr_sincos #(
  parameter int ANGLE_BITS    = afr_pkg::DEF_ANGLE_BITS,
  parameter int CORDIC_STAGES = afr_pkg::DEF_CORDIC_STAGES,
  parameter int AUX_W         = 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [ANGLE_BITS-1:0]        angle_i,
  input  wire logic [AUX_W-1:0]             aux_i,
  output logic                              valid_o,
  output logic signed [afr_pkg::VEC_W-1:0]  sin_o,
  output logic signed [afr_pkg::VEC_W-1:0]  cos_o,
  output logic [AUX_W-1:0]                  aux_o
);
  import afr_pkg::*;

  localparam int ZW = ANGLE_BITS + 2;
  localparam longint QTR_L = longint'(1) << (ANGLE_BITS - 2);
  localparam logic signed [ZW-1:0] QTR  = ZW'(QTR_L);
  localparam logic signed [ZW-1:0] HALF = ZW'(QTR_L * 2);
  localparam int LAST = CORDIC_STAGES - 1;

  logic signed [ZW-1:0] z_raw, z_fold;
  logic                 neg_fold;

  // Fold the angle into the right half-plane; the result is negated at the end.
  always_comb begin
    z_raw    = ZW'(signed'(angle_i));
    z_fold   = z_raw;
    neg_fold = 1'b0;
    priority if (z_raw > QTR) begin
      z_fold   = z_raw - HALF;
      neg_fold = 1'b1;
    end else if (z_raw < -QTR) begin
      z_fold   = z_raw + HALF;
      neg_fold = 1'b1;
    end
  end

  vec_t                 x_in [CORDIC_STAGES];
  vec_t                 y_in [CORDIC_STAGES];
  logic signed [ZW-1:0] z_in [CORDIC_STAGES];
  logic                 n_in [CORDIC_STAGES];
  logic                 v_in [CORDIC_STAGES];
  logic [AUX_W-1:0]     a_in [CORDIC_STAGES];

  vec_t                 x_q [CORDIC_STAGES];
  vec_t                 y_q [CORDIC_STAGES];
  logic signed [ZW-1:0] z_q [CORDIC_STAGES];
  logic                 n_q [CORDIC_STAGES];
  logic                 v_q [CORDIC_STAGES];
  logic [AUX_W-1:0]     a_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    localparam logic signed [ZW-1:0] ANG = ZW'(cordic_angle(i, ANGLE_BITS));
    vec_t                 x_d, y_d;
    logic signed [ZW-1:0] z_d;

    if (i == 0) begin : g_head
      assign x_in[i] = K_GAIN;
      assign y_in[i] = '0;
      assign z_in[i] = z_fold;
      assign n_in[i] = neg_fold;
      assign v_in[i] = valid_i;
      assign a_in[i] = aux_i;
    end else begin : g_link
      assign x_in[i] = x_q[i-1];
      assign y_in[i] = y_q[i-1];
      assign z_in[i] = z_q[i-1];
      assign n_in[i] = n_q[i-1];
      assign v_in[i] = v_q[i-1];
      assign a_in[i] = a_q[i-1];
    end

    always_comb begin
      if (z_in[i] >= 0) begin
        x_d = x_in[i] - (y_in[i] >>> i);
        y_d = y_in[i] + (x_in[i] >>> i);
        z_d = z_in[i] - ANG;
      end else begin
        x_d = x_in[i] + (y_in[i] >>> i);
        y_d = y_in[i] - (x_in[i] >>> i);
        z_d = z_in[i] + ANG;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
        n_q[i] <= n_in[i];
        a_q[i] <= a_in[i];
      end
    end
  end

  assign valid_o = v_q[LAST];
  assign sin_o   = n_q[LAST] ? -y_q[LAST] : y_q[LAST];
  assign cos_o   = n_q[LAST] ? -x_q[LAST] : x_q[LAST];
  assign aux_o   = a_q[LAST];

endmodule

`default_nettype wire

// ----- sv/afr_atan2.sv -----
// Vectoring-mode CORDIC chain giving atan2 of a vector as a binary angle.
`default_nettype none

module afr_atan2 #(
  parameter int ANGLE_BITS    = afr_pkg::DEF_ANGLE_BITS,
  parameter int CORDIC_STAGES = afr_pkg::DEF_CORDIC_STAGES,
  parameter int AUX_W         = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic signed [afr_pkg::VEC_W-1:0] y_i,
  input  wire logic signed [afr_pkg::VEC_W-1:0] x_i,
  input  wire logic [AUX_W-1:0]            aux_i,
  output logic                             valid_o,
  output logic [ANGLE_BITS-1:0]            angle_o,
  output logic [AUX_W-1:0]                 aux_o
);
  import afr_pkg::*;

  localparam int ZW = ANGLE_BITS + 2;
  localparam logic signed [ZW-1:0] HALF = ZW'(longint'(1) << (ANGLE_BITS - 1));
  localparam int LAST = CORDIC_STAGES - 1;

  vec_t                 x_f, y_f;
  logic signed [ZW-1:0] z_f;
  logic                 zero_f;

  // A vector in the left half-plane is turned by a half turn first.
  always_comb begin
    zero_f = (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      x_f = -x_i;
      y_f = -y_i;
      z_f = HALF;
    end else begin
      x_f = x_i;
      y_f = y_i;
      z_f = '0;
    end
  end

  vec_t                 x_in [CORDIC_STAGES];
  vec_t                 y_in [CORDIC_STAGES];
  logic signed [ZW-1:0] z_in [CORDIC_STAGES];
  logic                 o_in [CORDIC_STAGES];
  logic                 v_in [CORDIC_STAGES];
  logic [AUX_W-1:0]     a_in [CORDIC_STAGES];

  vec_t                 x_q [CORDIC_STAGES];
  vec_t                 y_q [CORDIC_STAGES];
  logic signed [ZW-1:0] z_q [CORDIC_STAGES];
  logic                 o_q [CORDIC_STAGES];
  logic                 v_q [CORDIC_STAGES];
  logic [AUX_W-1:0]     a_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    localparam logic signed [ZW-1:0] ANG = ZW'(cordic_angle(i, ANGLE_BITS));
    vec_t                 x_d, y_d;
    logic signed [ZW-1:0] z_d;

    if (i == 0) begin : g_head
      assign x_in[i] = x_f;
      assign y_in[i] = y_f;
      assign z_in[i] = z_f;
      assign o_in[i] = zero_f;
      assign v_in[i] = valid_i;
      assign a_in[i] = aux_i;
    end else begin : g_link
      assign x_in[i] = x_q[i-1];
      assign y_in[i] = y_q[i-1];
      assign z_in[i] = z_q[i-1];
      assign o_in[i] = o_q[i-1];
      assign v_in[i] = v_q[i-1];
      assign a_in[i] = a_q[i-1];
    end

    always_comb begin
      if (y_in[i] >= 0) begin
        x_d = x_in[i] + (y_in[i] >>> i);
        y_d = y_in[i] - (x_in[i] >>> i);
        z_d = z_in[i] + ANG;
      end else begin
        x_d = x_in[i] - (y_in[i] >>> i);
        y_d = y_in[i] + (x_in[i] >>> i);
        z_d = z_in[i] - ANG;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
        o_q[i] <= o_in[i];
        a_q[i] <= a_in[i];
      end
    end
  end

  // The zero vector maps to angle zero.
  assign valid_o = v_q[LAST];
  assign angle_o = o_q[LAST] ? '0 : z_q[LAST][ANGLE_BITS-1:0];
  assign aux_o   = a_q[LAST];

endmodule

`default_nettype wire

// ----- sv/afr_isqrt.sv -----
// Chain of digit-by-digit square root cells, two radicand bits per cell.
`default_nettype none

module afr_isqrt #(
  parameter int AUX_W = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [afr_pkg::SQ_W-1:0]    arg_i,
  input  wire logic [AUX_W-1:0]            aux_i,
  output logic                             valid_o,
  output logic [afr_pkg::Q_FRAC:0]         root_o,
  output logic [AUX_W-1:0]                 aux_o
);
  import afr_pkg::*;

  localparam int RW   = SQ_W + 1;
  localparam int LAST = SQRT_STAGES - 1;

  logic [SQ_W-1:0]  r_in [SQRT_STAGES];
  logic [RW-1:0]    s_in [SQRT_STAGES];
  logic             v_in [SQRT_STAGES];
  logic [AUX_W-1:0] a_in [SQRT_STAGES];

  logic [SQ_W-1:0]  r_q [SQRT_STAGES];
  logic [RW-1:0]    s_q [SQRT_STAGES];
  logic             v_q [SQRT_STAGES];
  logic [AUX_W-1:0] a_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_cell
    localparam logic [RW-1:0] BIT = RW'(longint'(1) << (2 * (Q_FRAC - k)));
    logic [RW-1:0]   trial;
    logic [SQ_W-1:0] r_d;
    logic [RW-1:0]   s_d;

    if (k == 0) begin : g_head
      assign r_in[k] = arg_i;
      assign s_in[k] = '0;
      assign v_in[k] = valid_i;
      assign a_in[k] = aux_i;
    end else begin : g_link
      assign r_in[k] = r_q[k-1];
      assign s_in[k] = s_q[k-1];
      assign v_in[k] = v_q[k-1];
      assign a_in[k] = a_q[k-1];
    end

    always_comb begin
      trial = s_in[k] + BIT;
      if (RW'(r_in[k]) >= trial) begin
        r_d = r_in[k] - trial[SQ_W-1:0];
        s_d = (s_in[k] >> 1) + BIT;
      end else begin
        r_d = r_in[k];
        s_d = s_in[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= r_d;
        s_q[k] <= s_d;
        a_q[k] <= a_in[k];
      end
    end
  end

  assign valid_o = v_q[LAST];
  assign root_o  = s_q[LAST][Q_FRAC:0];
  assign aux_o   = a_q[LAST];

endmodule

`default_nettype wire

// ----- sv/alt_az_field_rotation_angle.sv -----
// Top level: altitude, azimuth and field rotation angle from declination and hour angle.
// The path runs through four CORDIC cell rows, the 31-cell square root, nine multiply
// and add stages and the output register.
// Throughput is one request per cycle; every stage advances together unless a finished
// result waits in the output register while the receiver stalls.
// Reset clears every valid flag and sets the latitude register to zero.
`default_nettype none

module alt_az_field_rotation_angle #(
  parameter int ANGLE_BITS    = afr_pkg::DEF_ANGLE_BITS,
  parameter int CORDIC_STAGES = afr_pkg::DEF_CORDIC_STAGES
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic signed [31:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] declination_i,
  input  wire logic signed [31:0] hour_angle_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      altitude_o,
  output logic signed [31:0]      azimuth_o,
  output logic signed [31:0]      rotation_angle_o
);
  import afr_pkg::*;

  localparam int AW = ANGLE_BITS;

  // The whole pipeline moves as one unless the output register is full and stalled.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Site latitude; to be written only while the block is idle, which the block itself does not enforce.
  logic signed [31:0] latitude_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latitude_q <= '0;
    end else if (cfg_we_i) begin
      latitude_q <= cfg_wdata_i;
    end
  end

  // Conversion between the 32-bit port angles and the internal angle width.
  logic [AW-1:0] dec_a, ha_a, lat_a, alt_a, az_a, rot_a;
  logic [31:0]   alt_p, az_p, rot_p;

  if (AW > 32) begin : g_wide
    localparam int SH = AW - 32;
    localparam logic [AW:0] RND = (AW + 1)'(longint'(1) << (SH - 1));
    logic [AW:0] alt_r, az_r, rot_r;
    assign dec_a = {declination_i, {SH{1'b0}}};
    assign ha_a  = {hour_angle_i, {SH{1'b0}}};
    assign lat_a = {latitude_q, {SH{1'b0}}};
    // Round half up, then wrap.
    assign alt_r = {1'b0, alt_a} + RND;
    assign az_r  = {1'b0, az_a} + RND;
    assign rot_r = {1'b0, rot_a} + RND;
    assign alt_p = alt_r[SH+31:SH];
    assign az_p  = az_r[SH+31:SH];
    assign rot_p = rot_r[SH+31:SH];
  end else if (AW == 32) begin : g_same
    assign dec_a = declination_i;
    assign ha_a  = hour_angle_i;
    assign lat_a = latitude_q;
    assign alt_p = alt_a;
    assign az_p  = az_a;
    assign rot_p = rot_a;
  end else begin : g_narrow
    localparam int SH = 32 - AW;
    // Dropping the low bits truncates toward minus infinity.
    assign dec_a = declination_i[31:SH];
    assign ha_a  = hour_angle_i[31:SH];
    assign lat_a = latitude_q[31:SH];
    assign alt_p = {alt_a, {SH{1'b0}}};
    assign az_p  = {az_a, {SH{1'b0}}};
    assign rot_p = {rot_a, {SH{1'b0}}};
  end

  // Sines and cosines of declination, hour angle and latitude.
  vec_t sd, cd, sh, ch, sl, cl;
  logic v0;

  afr_sincos #(.ANGLE_BITS(AW), .CORDIC_STAGES(CORDIC_STAGES), .AUX_W(1)) u_sc_dec (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_valid_i), .angle_i(dec_a), .aux_i(1'b0),
    .valid_o(v0), .sin_o(sd), .cos_o(cd), .aux_o()
  );

  afr_sincos #(.ANGLE_BITS(AW), .CORDIC_STAGES(CORDIC_STAGES), .AUX_W(1)) u_sc_ha (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_valid_i), .angle_i(ha_a), .aux_i(1'b0),
    .valid_o(), .sin_o(sh), .cos_o(ch), .aux_o()
  );

  afr_sincos #(.ANGLE_BITS(AW), .CORDIC_STAGES(CORDIC_STAGES), .AUX_W(1)) u_sc_lat (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_valid_i), .angle_i(lat_a), .aux_i(1'b0),
    .valid_o(), .sin_o(sl), .cos_o(cl), .aux_o()
  );

  // Target direction p = Ry(L) Rz(H) Ry(-D) ex and the cross product s = p x (Ry(L) ez).
  vec_t wx_q, wy_q, wz_q, sl1_q, cl1_q;
  vec_t ma_q, mb_q, mc_q, md_q, wy2_q, sl2_q, cl2_q;
  vec_t px_q, py_q, pz_q, sl3_q, cl3_q;
  vec_t sx_q, t1_q, t2_q, sz_q, py4_q, pz4_q;
  logic signed [PS_W-1:0] ps_q;
  vec_t sy5_q, sx5_q, sz5_q, py5_q, pz5_q;
  logic signed [PS_W-1:0] ps5_q;
  logic [SQ_W-1:0] sq5_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  logic signed [PS_W-1:0] ps_d;
  logic [PS_W-2:0]        ps_mag;

  // The asin argument saturates at plus and minus one.
  always_comb begin
    if (px_q > ONE_Q30) begin
      ps_d = PS_W'(ONE_Q30);
    end else if (px_q < -ONE_Q30) begin
      ps_d = -PS_W'(ONE_Q30);
    end else begin
      ps_d = PS_W'(px_q);
    end
  end

  assign ps_mag = ps_q[PS_W-1] ? (PS_W-1)'(-ps_q) : ps_q[PS_W-2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx_q  <= mulq(ch, cd);
      wy_q  <= mulq(sh, cd);
      wz_q  <= sd;
      sl1_q <= sl;
      cl1_q <= cl;

      ma_q  <= mulq(cl1_q, wx_q);
      mb_q  <= mulq(sl1_q, wz_q);
      mc_q  <= mulq(cl1_q, wz_q);
      md_q  <= mulq(sl1_q, wx_q);
      wy2_q <= wy_q;
      sl2_q <= sl1_q;
      cl2_q <= cl1_q;

      px_q  <= ma_q + mb_q;
      py_q  <= wy2_q;
      pz_q  <= mc_q - md_q;
      sl3_q <= sl2_q;
      cl3_q <= cl2_q;

      sx_q  <= mulq(py_q, cl3_q);
      t1_q  <= mulq(pz_q, sl3_q);
      t2_q  <= mulq(px_q, cl3_q);
      sz_q  <= -mulq(py_q, sl3_q);
      ps_q  <= ps_d;
      py4_q <= py_q;
      pz4_q <= pz_q;

      sy5_q <= t1_q - t2_q;
      sq5_q <= SQ_W'(ps_mag * ps_mag);
      sx5_q <= sx_q;
      sz5_q <= sz_q;
      ps5_q <= ps_q;
      py5_q <= py4_q;
      pz5_q <= pz4_q;
    end
  end

  // Cosine of altitude as sqrt(1 - p.x^2), carrying the rest alongside.
  localparam int SQ_AUX = PS_W + 5 * VEC_W;
  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(longint'(1) << (2 * Q_FRAC));

  logic [SQ_AUX-1:0]      sq_aux;
  logic                   v6;
  logic [Q_FRAC:0]        pc6;
  logic signed [PS_W-1:0] ps6;
  vec_t                   py6, pz6, sx6, sy6, sz6;

  afr_isqrt #(.AUX_W(SQ_AUX)) u_isqrt (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v5_q), .arg_i(ONE_SQ - sq5_q),
    .aux_i({ps5_q, py5_q, pz5_q, sx5_q, sy5_q, sz5_q}),
    .valid_o(v6), .root_o(pc6), .aux_o(sq_aux)
  );

  assign {ps6, py6, pz6, sx6, sy6, sz6} = sq_aux;

  // Altitude and azimuth.
  logic [AW-1:0] alt7, az7;
  logic          v7;
  vec_t          sx7, sy7, sz7;

  afr_atan2 #(.ANGLE_BITS(AW), .CORDIC_STAGES(CORDIC_STAGES), .AUX_W(VEC_W)) u_at_alt (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v6),
    .y_i(VEC_W'(ps6)), .x_i(VEC_W'(signed'({1'b0, pc6}))),
    .aux_i(sx6), .valid_o(v7), .angle_o(alt7), .aux_o(sx7)
  );

  afr_atan2 #(.ANGLE_BITS(AW), .CORDIC_STAGES(CORDIC_STAGES), .AUX_W(2*VEC_W)) u_at_az (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v6), .y_i(py6), .x_i(pz6),
    .aux_i({sy6, sz6}), .valid_o(), .angle_o(az7), .aux_o({sy7, sz7})
  );

  // Sines and cosines of altitude and azimuth.
  vec_t          sa8, ca8, sz8s, cz8, sx8, sy8, sz8;
  logic [AW-1:0] alt8, az8;
  logic          v8;

  afr_sincos #(.ANGLE_BITS(AW), .CORDIC_STAGES(CORDIC_STAGES), .AUX_W(AW+VEC_W)) u_sc_alt (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v7), .angle_i(alt7), .aux_i({alt7, sx7}),
    .valid_o(v8), .sin_o(sa8), .cos_o(ca8), .aux_o({alt8, sx8})
  );

  afr_sincos #(.ANGLE_BITS(AW), .CORDIC_STAGES(CORDIC_STAGES), .AUX_W(AW+2*VEC_W)) u_sc_az (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v7), .angle_i(az7), .aux_i({az7, sy7, sz7}),
    .valid_o(), .sin_o(sz8s), .cos_o(cz8), .aux_o({az8, sy8, sz8})
  );

  // v = Ry(-alt) Rx(az) s: rotate by azimuth, then by altitude.
  vec_t r1a_q, r1b_q, r1c_q, r1d_q, sa1_q, ca1_q, rx1_q;
  vec_t ry2_q, rz2_q, rx2_q, sa2_q, ca2_q;
  vec_t ma3_q, mb3_q, ry3_q;
  vec_t vx4_q, vy4_q;
  logic [AW-1:0] alt1_q, az1_q, alt2_q, az2_q, alt3_q, az3_q, alt4_q, az4_q;
  logic          w1_q, w2_q, w3_q, w4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q <= 1'b0;
      w2_q <= 1'b0;
      w3_q <= 1'b0;
      w4_q <= 1'b0;
    end else if (adv) begin
      w1_q <= v8;
      w2_q <= w1_q;
      w3_q <= w2_q;
      w4_q <= w3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1a_q  <= mulq(cz8, sy8);
      r1b_q  <= mulq(sz8s, sz8);
      r1c_q  <= mulq(sz8s, sy8);
      r1d_q  <= mulq(cz8, sz8);
      sa1_q  <= sa8;
      ca1_q  <= ca8;
      rx1_q  <= sx8;
      alt1_q <= alt8;
      az1_q  <= az8;

      ry2_q  <= r1a_q - r1b_q;
      rz2_q  <= r1c_q + r1d_q;
      rx2_q  <= rx1_q;
      sa2_q  <= sa1_q;
      ca2_q  <= ca1_q;
      alt2_q <= alt1_q;
      az2_q  <= az1_q;

      ma3_q  <= mulq(ca2_q, rx2_q);
      mb3_q  <= mulq(sa2_q, rz2_q);
      ry3_q  <= ry2_q;
      alt3_q <= alt2_q;
      az3_q  <= az2_q;

      vx4_q  <= ma3_q - mb3_q;
      vy4_q  <= ry3_q;
      alt4_q <= alt3_q;
      az4_q  <= az3_q;
    end
  end

  // Field rotation is the negated angle of v in its x-y plane.
  logic [AW-1:0] vang;
  logic          v9;

  afr_atan2 #(.ANGLE_BITS(AW), .CORDIC_STAGES(CORDIC_STAGES), .AUX_W(2*AW)) u_at_rot (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(w4_q), .y_i(vx4_q), .x_i(vy4_q),
    .aux_i({alt4_q, az4_q}), .valid_o(v9), .angle_o(vang), .aux_o({alt_a, az_a})
  );

  assign rot_a = AW'(0) - vang;

  // Output register: holds a finished result while the receiver stalls.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v9;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      altitude_o       <= alt_p;
      azimuth_o        <= az_p;
      rotation_angle_o <= rot_p;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
